FILE: rtl/centered_moving_average_unit_defines.svh
// ---------------------------------------------------------------------------
// centered moving average unit assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef CENTERED_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_UNIT_DEFINES_SVH

// checked only out of reset
`define CMA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cma_pkg.sv
// ---------------------------------------------------------------------------
// cma_pkg
// types and fixed widths of the centered moving average unit
// ---------------------------------------------------------------------------
package cma_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int WIDTH_REG_W = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // register index as held in paddr bit 2
  localparam logic REG_WINDOW_WIDTH = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAKE_CHK,
    S_TAKE_WB,
    S_WRITE,
    S_DIV,
    S_EMIT,
    S_DRAIN_CHK,
    S_DRAIN_WB
  } state_t;

endpackage

FILE: rtl/centered_moving_average_unit.sv
// ---------------------------------------------------------------------------
// centered moving average unit
// centered window mean over runs of per-base samples, ring held in a memory
// ---------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | tvalid / tready      | tdata sample_value, tlast run_last
//  out_    | out | tvalid / tready      | tdata mean_value, tlast run_end
//  cfg_    | in  | apb, pready always 1 | window_width at byte address 0
//
//  one item at a time: each item is taken, each sample dropped from the ring is
//  checked and subtracted in its own step, the item is written, and each result
//  runs through the bit-serial divider; a run's last item adds a closing step,
//  and up to floor(W/2) drain results, each after its own drops and division
//  rst_n is synchronous; the ring has no reset and no clearing pass
//  a result waits while the output register is full; a held result lets the next item in
// ---------------------------------------------------------------------------
module centered_moving_average_unit #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cma_pkg::SAMPLE_W-1:0]       in_tdata,   // [31:0] sample_value
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cma_pkg::SAMPLE_W-1:0]       out_tdata,  // [31:0] mean_value
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [cma_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cma_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cma_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import cma_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int SLOT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WIDTH);
  localparam int DIVC_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_WIDTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WIDTH - 1);
  localparam logic [DIVC_W-1:0] DIV_LAST  = DIVC_W'(SUM_W - 1);

  state_t                  state_r, state_nxt;
  logic [WIDTH_REG_W-1:0]  width_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        held_r, held_nxt;
  logic [SLOT_W-1:0]       write_slot_r, write_slot_nxt;
  logic [SLOT_W-1:0]       oldest_slot_r, oldest_slot_nxt;
  logic [CNT_W-1:0]        run_r, run_nxt;
  logic [CNT_W-1:0]        drain_r, drain_nxt;
  logic [DIVC_W-1:0]       divc_r, divc_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [SAMPLE_W-1:0]     sample_r, sample_nxt;
  logic                    last_r, last_nxt;
  logic [SUM_W-1:0]        quo_r, quo_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]        div_r, div_nxt;
  logic                    neg_r, neg_nxt;
  logic                    end_r, end_nxt;
  logic [SAMPLE_W-1:0]     out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [SAMPLE_W-1:0]     ring_mem [MAX_WIDTH];
  logic [SAMPLE_W-1:0]     ring_rdata_r;
  logic                    ring_we;

  logic [8:0]              width_ext;
  logic [CNT_W-1:0]        w_eff, h_eff;
  logic [CNT_W-1:0]        run_new;
  logic signed [SUM_W-1:0] sum_add, sum_drop;
  logic [CNT_W:0]          target;
  logic [CNT_W:0]          trial, diff;
  logic                    ge;
  logic [SUM_W-1:0]        quo_signed;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SUM_W-1:0] magnitude(input logic [SUM_W-1:0] s);
    return s[SUM_W-1] ? (~s + 1'b1) : s;
  endfunction

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_WIDTH) ?
                      CFG_DATA_W'(width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_REG_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_WINDOW_WIDTH) begin
      width_r <= cfg_pwdata[WIDTH_REG_W-1:0];
    end
  end

  // effective width and half width
  always_comb begin
    width_ext = 9'(width_r);
    if (width_ext == '0) begin
      w_eff = CNT_W'(1);
    end else if (width_ext > 9'(MAX_WIDTH)) begin
      w_eff = MAX_CNT;
    end else begin
      w_eff = CNT_W'(width_ext);
    end
    h_eff = w_eff >> 1;
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[write_slot_r] <= sample_r;
    end
    ring_rdata_r <= ring_mem[oldest_slot_r];
  end

  assign run_new  = (run_r < MAX_CNT) ? run_r + 1'b1 : run_r;
  assign sum_add  = sum_r + SUM_W'(signed'(sample_r));
  assign sum_drop = sum_r - SUM_W'(signed'(ring_rdata_r));
  assign target   = (CNT_W+1)'(drain_r) - 1'b1 + (CNT_W+1)'(w_eff) - (CNT_W+1)'(h_eff);
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign diff     = trial - (CNT_W+1)'(div_r);
  assign ge       = (trial >= (CNT_W+1)'(div_r));
  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt       = state_r;
    sum_nxt         = sum_r;
    held_nxt        = held_r;
    write_slot_nxt  = write_slot_r;
    oldest_slot_nxt = oldest_slot_r;
    run_nxt         = run_r;
    drain_nxt       = drain_r;
    divc_nxt        = divc_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    sample_nxt      = sample_r;
    last_nxt        = last_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    div_nxt         = div_r;
    neg_nxt         = neg_r;
    end_nxt         = end_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    ring_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata;
          last_nxt   = in_tlast;
          state_nxt  = S_TAKE_CHK;
        end
      end
      S_TAKE_CHK: begin
        state_nxt = (held_r >= w_eff) ? S_TAKE_WB : S_WRITE;
      end
      S_TAKE_WB: begin
        sum_nxt         = sum_drop;
        oldest_slot_nxt = next_slot(oldest_slot_r);
        held_nxt        = held_r - 1'b1;
        state_nxt       = S_TAKE_CHK;
      end
      S_WRITE: begin
        ring_we        = 1'b1;
        sum_nxt        = sum_add;
        write_slot_nxt = next_slot(write_slot_r);
        held_nxt       = held_r + 1'b1;
        run_nxt        = run_new;
        drain_nxt      = last_r ? ((h_eff < run_new) ? h_eff : run_new) : '0;
        if (run_new > h_eff) begin
          quo_nxt   = magnitude(sum_add);
          neg_nxt   = sum_add[SUM_W-1];
          div_nxt   = held_r + 1'b1;
          rem_nxt   = '0;
          divc_nxt  = '0;
          end_nxt   = last_r && (h_eff == '0);
          state_nxt = S_DIV;
        end else begin
          state_nxt = last_r ? S_DRAIN_CHK : S_IDLE;
        end
      end
      S_DIV: begin
        rem_nxt  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_nxt  = {quo_r[SUM_W-2:0], ge};
        divc_nxt = divc_r + 1'b1;
        if (divc_r == DIV_LAST) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = quo_signed[SAMPLE_W-1:0];
          out_last_nxt  = end_r;
          state_nxt     = last_r ? S_DRAIN_CHK : S_IDLE;
        end
      end
      S_DRAIN_CHK: begin
        if (drain_r == '0) begin
          sum_nxt         = '0;
          held_nxt        = '0;
          write_slot_nxt  = '0;
          oldest_slot_nxt = '0;
          run_nxt         = '0;
          state_nxt       = S_IDLE;
        end else if ((CNT_W+1)'(held_r) > target) begin
          state_nxt = S_DRAIN_WB;
        end else begin
          quo_nxt   = magnitude(sum_r);
          neg_nxt   = sum_r[SUM_W-1];
          div_nxt   = held_r;
          rem_nxt   = '0;
          divc_nxt  = '0;
          end_nxt   = (drain_r == CNT_W'(1));
          drain_nxt = drain_r - 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DRAIN_WB: begin
        sum_nxt         = sum_drop;
        oldest_slot_nxt = next_slot(oldest_slot_r);
        held_nxt        = held_r - 1'b1;
        state_nxt       = S_DRAIN_CHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sum_r         <= '0;
      held_r        <= '0;
      write_slot_r  <= '0;
      oldest_slot_r <= '0;
      run_r         <= '0;
      drain_r       <= '0;
      divc_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sum_r         <= sum_nxt;
      held_r        <= held_nxt;
      write_slot_r  <= write_slot_nxt;
      oldest_slot_r <= oldest_slot_nxt;
      run_r         <= run_nxt;
      drain_r       <= drain_nxt;
      divc_r        <= divc_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    last_r     <= last_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    neg_r      <= neg_nxt;
    end_r      <= end_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

FILE: rtl/cma_checker.sv
// ---------------------------------------------------------------------------
// cma_checker
// port-level assertions for the centered moving average unit
// ---------------------------------------------------------------------------
`include "centered_moving_average_unit_defines.svh"

module cma_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [cma_pkg::SAMPLE_W-1:0] out_tdata,   // [31:0] mean_value
  input logic                         out_tlast
);

  `CMA_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `CMA_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `CMA_ASSERT(a_busy_after_take, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "item taken while previous item in progress")
  `CMA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind centered_moving_average_unit cma_checker u_cma_checker (.*);

FILE: tb/cma_mean_checker.sv
// ---------------------------------------------------------------------------
// centered moving average checker
// watches the sample, result and register channels of the unit, keeps its
// own window state, predicts every mean and checks each result in order
// ---------------------------------------------------------------------------
module cma_mean_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [cma_pkg::SAMPLE_W-1:0]   in_tdata,   // [31:0] sample_value
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [cma_pkg::SAMPLE_W-1:0]   out_tdata,  // [31:0] mean_value
  input  logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cma_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cma_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                           cfg_pready,
  output int                             fail_count,
  output int                             pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_MAX = 64;
  localparam int REPORT_CAP = 20;

  typedef struct packed {
    logic [cma_pkg::SAMPLE_W-1:0] mean_value;
    logic                         run_end;
  } mean_t;

  mean_t                              expected_means[$];
  mean_t                              oldest_mean;
  logic [cma_pkg::WIDTH_REG_W-1:0]    width_reg;
  logic signed [cma_pkg::SAMPLE_W-1:0] sample_ring [WINDOW_MAX];
  logic signed [37:0]                 running_sum;
  logic [6:0]                         held;
  logic [5:0]                         write_slot;
  logic [5:0]                         oldest_slot;
  logic [6:0]                         run_count;

  task automatic clear_window();
    running_sum = '0;
    held        = '0;
    write_slot  = '0;
    oldest_slot = '0;
    run_count   = '0;
  endtask

  task automatic drop_oldest_sample();
    if (held != 0) begin
      running_sum = running_sum - sample_ring[oldest_slot];
      oldest_slot = oldest_slot + 6'd1;
      held        = held - 7'd1;
    end
  endtask

  task automatic post_mean(input logic last_pos);
    logic signed [37:0] divisor;
    logic signed [37:0] quotient;
    mean_t              m;
    quotient = '0;
    if (held != 0) begin
      divisor  = {31'd0, held};
      quotient = running_sum / divisor;
    end
    m.mean_value = quotient[cma_pkg::SAMPLE_W-1:0];
    m.run_end    = last_pos;
    expected_means.push_back(m);
  endtask

  task automatic predict_means(input logic signed [cma_pkg::SAMPLE_W-1:0] value,
                               input logic last);
    int w;
    int h;
    int drains;
    int target;
    int d;
    if (width_reg == 0)
      w = 1;
    else if (width_reg > WINDOW_MAX)
      w = WINDOW_MAX;
    else
      w = int'(width_reg);
    h = w / 2;

    while (int'(held) >= w) drop_oldest_sample();
    sample_ring[write_slot] = value;
    running_sum = running_sum + value;
    write_slot  = write_slot + 6'd1;
    held        = held + 7'd1;
    if (run_count < WINDOW_MAX)
      run_count = run_count + 7'd1;

    if (int'(run_count) >= h + 1)
      post_mean(last && h == 0);

    if (last) begin
      drains = (h < int'(run_count)) ? h : int'(run_count);
      for (d = drains; d > 0; d--) begin
        target = d - 1 + w - h;
        while (int'(held) > target) drop_oldest_sample();
        post_mean(d == 1);
      end
      clear_window();
    end
  endtask

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = 7'd1;
      clear_window();
      expected_means.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_means.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t unexpected result: expected none, got mean_value %h run_end %b",
                     $time, out_tdata, out_tlast);
        end else begin
          oldest_mean = expected_means.pop_front();
          if (out_tdata !== oldest_mean.mean_value) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
              $display("%0t mean_value mismatch: expected %h, got %h",
                       $time, oldest_mean.mean_value, out_tdata);
          end
          if (out_tlast !== oldest_mean.run_end) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
              $display("%0t run_end mismatch: expected %b, got %b",
                       $time, oldest_mean.run_end, out_tlast);
          end
        end
      end

      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == cma_pkg::REG_WINDOW_WIDTH)
        width_reg = cfg_pwdata[cma_pkg::WIDTH_REG_W-1:0];

      if (in_tvalid && in_tready)
        predict_means(in_tdata, in_tlast);
    end
    pending_results <= expected_means.size();
  end

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// centered moving average unit testbench
// drives runs of samples and window widths, with random idling on both
// channels; the checker predicts and compares, the top gives the verdict
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 200;
  localparam int DRAIN_CYCLES  = 300;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 30;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [cma_pkg::SAMPLE_W-1:0]   in_tdata = '0;   // [31:0] sample_value
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [cma_pkg::SAMPLE_W-1:0]   out_tdata;       // [31:0] mean_value
  logic                           out_tlast;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [cma_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [cma_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [cma_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  int fail_count;
  int pending_results;
  int tx_idle_pct = 7;
  int rx_idle_pct = 79;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  centered_moving_average_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  cma_mean_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // no item on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [cma_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(131071)) - 32'd65536;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [cma_pkg::WIDTH_REG_W-1:0] pick_width();
    case ($urandom_range(9))
      0:       return 7'd1;
      1:       return 7'd64;
      2:       return 7'd0;
      3:       return 7'($urandom_range(65, 127));
      4:       return 7'd2;
      default: return 7'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic send_sample(input logic [cma_pkg::SAMPLE_W-1:0] value, input logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_run(input int len, input logic close_run);
    int i;
    for (i = 0; i < len; i++)
      send_sample(pick_sample(), close_run && i == len - 1);
  endtask

  // sender holds off until every mean is out and the unit has gone quiet
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window_width(input logic [cma_pkg::WIDTH_REG_W-1:0] w);
    hold_until_drained();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {cma_pkg::REG_WINDOW_WIDTH, 2'b00};
    cfg_pwdata  <= {{(cma_pkg::CFG_DATA_W - cma_pkg::WIDTH_REG_W){1'b0}}, w};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    int phase;
    int sent;
    int len;
    int split;
    int i;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // width one out of reset, extremes
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    // zero width behaves as one, single-sample run
    set_window_width(7'd0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    // widest window, run shorter than half of it
    set_window_width(7'd64);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    // over-wide setting saturates
    set_window_width(7'd127);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    // odd window over a longer run
    set_window_width(7'd5);
    for (i = 0; i < 8; i++)
      send_sample(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 7);
    // narrower window taking over mid-run
    set_window_width(7'd6);
    send_run(4, 1'b0);
    set_window_width(7'd3);
    send_run(3, 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 79 : 0;
      rx_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 7 : 0;
      if (phase == 2) begin
        // long run so the position count saturates
        set_window_width(7'd64);
        send_run(70, 1'b1);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        set_window_width(pick_width());
        len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        if ($urandom_range(3) == 0 && len >= 2) begin
          split = $urandom_range(1, len - 1);
          send_run(split, 1'b0);
          set_window_width(pick_width());
          send_run(len - split, 1'b1);
        end else begin
          send_run(len, 1'b1);
        end
        sent += len;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
